### hdl/dmcm_pkg.sv
// ----------------------------------------------------------------------------
// dmcm_pkg
// Shared types and constants of the diagram matching cost matrix block.
// ----------------------------------------------------------------------------
package dmcm_pkg;

   // Fixed-point layout of the item fields.
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 32;
   localparam int DIFF_W    = VAL_W + 1;
   localparam int COST_W    = 48;
   localparam int STATUS_W  = 2;
   localparam int SIZE_W    = 10;
   localparam int IDX_W     = 9;
   localparam int OPC_W     = 3;
   localparam int ENTRY_W   = 2 * VAL_W + 1;

   localparam logic [DIFF_W-1:0] ONE_FIX = DIFF_W'(1) << FRAC_BITS;

   // Opcodes.
   localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OPC_W-1:0] OP_LOAD_A = 3'd1;
   localparam logic [OPC_W-1:0] OP_LOAD_B = 3'd2;
   localparam logic [OPC_W-1:0] OP_FINISH = 3'd3;
   localparam logic [OPC_W-1:0] OP_READ   = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_READY = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIN_PAIR,
      S_FIN_DIAG_A,
      S_FIN_DIAG_B,
      S_FIN_DRAIN,
      S_FIN_MUL,
      S_FIN_SUM,
      S_RD_ISSUE,
      S_RD_WAIT
   } state_type;

   // Operation carried down the cost unit pipeline.
   typedef enum logic [1:0] {
      UOP_PAIR,
      UOP_DIAG_A,
      UOP_DIAG_B
   } uop_type;

   // One stored persistence pair.
   typedef struct packed {
      logic              infinite;
      logic [VAL_W-1:0]  death;
      logic [VAL_W-1:0]  birth;
   } entry_type;

   // Result handed to the output register.
   typedef struct packed {
      logic                fire;
      logic [COST_W-1:0]   cost;
      logic [STATUS_W-1:0] status;
   } resp_type;

endpackage

### hdl/dmcm_ram.sv
// ----------------------------------------------------------------------------
// dmcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/diagram_matching_cost_matrix.sv
// ----------------------------------------------------------------------------
// diagram_matching_cost_matrix
// Loads two persistence diagrams, finds the largest finite matching cost and
// the penalty, and returns entries of the augmented bottleneck cost matrix.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------
//   request   req_opcode/birth/death/infinite/row/col  start high, busy low
//   result    rsp_cost, rsp_status, rsp_size          rsp_valid, one cycle
//
// Clear, load and unused opcodes, and reads that fail, are answered in the
// cycle after the accepting edge. A read in the penalty or zero region passes
// through the issue state; a read of a pair or diagonal cost goes on through
// the registered store read and the two-stage cost unit. Finish walks every
// pair and every diagonal term once through one shared cost unit (and goes
// straight to the drain when both stores are empty), then drains, multiplies
// and saturates. Busy drops in the strobe cycle, so the next item may be taken
// at the edge that ends it; the result cannot be held off. Reset clears
// counts, the ready flag and the penalty; the stores keep no reset value.
//
module diagram_matching_cost_matrix #(
   parameter int MAX_PAIRS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dmcm_pkg::OPC_W-1:0]           req_opcode,
   input  logic signed [dmcm_pkg::VAL_W-1:0]    req_birth,
   input  logic signed [dmcm_pkg::VAL_W-1:0]    req_death,
   input  logic                                 req_infinite,
   input  logic [dmcm_pkg::IDX_W-1:0]           req_row,
   input  logic [dmcm_pkg::IDX_W-1:0]           req_col,
   output logic                                 rsp_valid,
   output logic [dmcm_pkg::COST_W-1:0]          rsp_cost,
   output logic [dmcm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [dmcm_pkg::SIZE_W-1:0]          rsp_size
);

   localparam int AW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
   localparam int XW     = (CNT_W + 1 > dmcm_pkg::SIZE_W) ? CNT_W + 1 : dmcm_pkg::SIZE_W;
   localparam int PROD_W = dmcm_pkg::DIFF_W + XW;
   localparam int SUM_W  = (PROD_W + 1 > dmcm_pkg::COST_W + 1) ? PROD_W + 1
                                                              : dmcm_pkg::COST_W + 1;
   localparam int DW     = dmcm_pkg::DIFF_W;

   dmcm_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]   count_a_ff, count_b_ff;
   logic [CNT_W-1:0]   i_ff, j_ff;
   logic               ready_ff;
   logic [DW-1:0]      max_ff;
   logic [dmcm_pkg::COST_W-1:0] penalty_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [dmcm_pkg::IDX_W-1:0] row_ff, col_ff;

   logic               rsp_valid_ff;
   logic [dmcm_pkg::COST_W-1:0]   rsp_cost_ff;
   logic [dmcm_pkg::STATUS_W-1:0] rsp_status_ff;

   // Cost unit pipeline.
   logic               rd_vld_ff, s1_vld_ff, s2_vld_ff;
   dmcm_pkg::uop_type  rd_op_ff, s1_op_ff;
   logic [DW-1:0]      s1_d1_ff, s1_d2_ff;
   logic               s1_inf_a_ff, s1_inf_b_ff;
   logic [DW-1:0]      s2_val_ff;
   logic               s2_fin_ff;

   logic               accept;
   logic [XW-1:0]      n_cur, row_x, col_x, cnt_a_x, cnt_b_x;
   logic               full_a, full_b, req_in_range;
   logic               pair_last, a_last, b_last, pipe_empty;
   logic               in_a, in_b, diag_a_hit, diag_b_hit, rd_direct;
   logic [dmcm_pkg::COST_W-1:0] rd_direct_cost;
   logic [SUM_W-1:0]   pen_sum;
   logic [dmcm_pkg::COST_W-1:0] pen_sat;

   logic               iss_vld;
   dmcm_pkg::uop_type  iss_op;
   logic [AW-1:0]      addr_a, addr_b;
   dmcm_pkg::resp_type resp;

   logic               wr_a, wr_b;
   dmcm_pkg::entry_type wr_entry, ent_a, ent_b;

   // ------------------------------------------------------------------------
   // Common decode
   // ------------------------------------------------------------------------
   assign accept  = start && !busy;
   assign busy    = (state_ff != dmcm_pkg::S_IDLE);
   assign cnt_a_x = XW'(count_a_ff);
   assign cnt_b_x = XW'(count_b_ff);
   assign n_cur   = cnt_a_x + cnt_b_x;
   assign full_a  = (count_a_ff >= CNT_W'(MAX_PAIRS));
   assign full_b  = (count_b_ff >= CNT_W'(MAX_PAIRS));
   assign req_in_range = (XW'(req_row) < n_cur) && (XW'(req_col) < n_cur);

   assign pair_last = ((XW'(i_ff) + XW'(1)) == cnt_a_x) && ((XW'(j_ff) + XW'(1)) == cnt_b_x);
   assign a_last    = (XW'(i_ff) + XW'(1)) == cnt_a_x;
   assign b_last    = (XW'(j_ff) + XW'(1)) == cnt_b_x;
   assign pipe_empty = !rd_vld_ff && !s1_vld_ff && !s2_vld_ff;

   // Region of the latched read within the augmented matrix.
   assign row_x      = XW'(row_ff);
   assign col_x      = XW'(col_ff);
   assign in_a       = row_x < cnt_a_x;
   assign in_b       = col_x < cnt_b_x;
   assign diag_a_hit = (col_x - cnt_b_x) == row_x;
   assign diag_b_hit = (row_x - cnt_a_x) == col_x;
   assign rd_direct  = !(in_a && in_b) && !(in_a && diag_a_hit) && !(in_b && diag_b_hit);
   assign rd_direct_cost = (!in_a && !in_b) ? '0 : penalty_ff;

   // Penalty: largest cost times (n + 1) plus one, saturated.
   assign pen_sum = SUM_W'(prod_ff) + SUM_W'(dmcm_pkg::ONE_FIX);
   assign pen_sat = (|pen_sum[SUM_W-1:dmcm_pkg::COST_W]) ? '1
                                                         : pen_sum[dmcm_pkg::COST_W-1:0];

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmcm_pkg::S_IDLE: begin
            if (accept && req_opcode == dmcm_pkg::OP_FINISH) begin
               if (count_a_ff != '0 && count_b_ff != '0) begin
                  state_in = dmcm_pkg::S_FIN_PAIR;
               end else if (count_a_ff != '0) begin
                  state_in = dmcm_pkg::S_FIN_DIAG_A;
               end else if (count_b_ff != '0) begin
                  state_in = dmcm_pkg::S_FIN_DIAG_B;
               end else begin
                  state_in = dmcm_pkg::S_FIN_DRAIN;
               end
            end else if (accept && req_opcode == dmcm_pkg::OP_READ && ready_ff &&
                         req_in_range) begin
               state_in = dmcm_pkg::S_RD_ISSUE;
            end
         end
         dmcm_pkg::S_FIN_PAIR: begin
            if (pair_last) begin
               state_in = dmcm_pkg::S_FIN_DIAG_A;
            end
         end
         dmcm_pkg::S_FIN_DIAG_A: begin
            if (a_last) begin
               state_in = (count_b_ff != '0) ? dmcm_pkg::S_FIN_DIAG_B
                                             : dmcm_pkg::S_FIN_DRAIN;
            end
         end
         dmcm_pkg::S_FIN_DIAG_B: begin
            if (b_last) begin
               state_in = dmcm_pkg::S_FIN_DRAIN;
            end
         end
         dmcm_pkg::S_FIN_DRAIN: begin
            if (pipe_empty) begin
               state_in = dmcm_pkg::S_FIN_MUL;
            end
         end
         dmcm_pkg::S_FIN_MUL: state_in = dmcm_pkg::S_FIN_SUM;
         dmcm_pkg::S_FIN_SUM: state_in = dmcm_pkg::S_IDLE;
         dmcm_pkg::S_RD_ISSUE: begin
            state_in = rd_direct ? dmcm_pkg::S_IDLE : dmcm_pkg::S_RD_WAIT;
         end
         dmcm_pkg::S_RD_WAIT: begin
            if (s2_vld_ff) begin
               state_in = dmcm_pkg::S_IDLE;
            end
         end
         default: state_in = dmcm_pkg::S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // State outputs: store reads into the cost unit and results
   // ------------------------------------------------------------------------
   always_comb begin
      iss_vld     = 1'b0;
      iss_op      = dmcm_pkg::UOP_PAIR;
      addr_a      = i_ff[AW-1:0];
      addr_b      = j_ff[AW-1:0];
      resp.fire   = 1'b0;
      resp.cost   = '0;
      resp.status = dmcm_pkg::STAT_OK;
      unique case (state_ff)
         dmcm_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  dmcm_pkg::OP_FINISH: resp.fire = 1'b0;
                  dmcm_pkg::OP_LOAD_A: begin
                     resp.fire   = 1'b1;
                     resp.status = full_a ? dmcm_pkg::STAT_FULL : dmcm_pkg::STAT_OK;
                  end
                  dmcm_pkg::OP_LOAD_B: begin
                     resp.fire   = 1'b1;
                     resp.status = full_b ? dmcm_pkg::STAT_FULL : dmcm_pkg::STAT_OK;
                  end
                  dmcm_pkg::OP_READ: begin
                     if (!ready_ff) begin
                        resp.fire   = 1'b1;
                        resp.status = dmcm_pkg::STAT_NOT_READY;
                     end else if (!req_in_range) begin
                        resp.fire   = 1'b1;
                        resp.status = dmcm_pkg::STAT_RANGE;
                     end
                  end
                  default: resp.fire = 1'b1;
               endcase
            end
         end
         dmcm_pkg::S_FIN_PAIR: begin
            iss_vld = 1'b1;
            iss_op  = dmcm_pkg::UOP_PAIR;
         end
         dmcm_pkg::S_FIN_DIAG_A: begin
            iss_vld = 1'b1;
            iss_op  = dmcm_pkg::UOP_DIAG_A;
         end
         dmcm_pkg::S_FIN_DIAG_B: begin
            iss_vld = 1'b1;
            iss_op  = dmcm_pkg::UOP_DIAG_B;
         end
         dmcm_pkg::S_FIN_DRAIN, dmcm_pkg::S_FIN_MUL: resp.fire = 1'b0;
         dmcm_pkg::S_FIN_SUM: begin
            resp.fire = 1'b1;
            resp.cost = pen_sat;
         end
         dmcm_pkg::S_RD_ISSUE: begin
            addr_a = row_x[AW-1:0];
            addr_b = col_x[AW-1:0];
            if (rd_direct) begin
               resp.fire = 1'b1;
               resp.cost = rd_direct_cost;
            end else begin
               iss_vld = 1'b1;
               if (in_a && in_b) begin
                  iss_op = dmcm_pkg::UOP_PAIR;
               end else if (in_a) begin
                  iss_op = dmcm_pkg::UOP_DIAG_A;
               end else begin
                  iss_op = dmcm_pkg::UOP_DIAG_B;
               end
            end
         end
         dmcm_pkg::S_RD_WAIT: begin
            if (s2_vld_ff) begin
               resp.fire = 1'b1;
               resp.cost = s2_fin_ff ? dmcm_pkg::COST_W'(s2_val_ff) : penalty_ff;
            end
         end
         default: resp.fire = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Stores
   // ------------------------------------------------------------------------
   assign wr_entry.infinite = req_infinite;
   assign wr_entry.death    = req_death;
   assign wr_entry.birth    = req_birth;
   assign wr_a = accept && (req_opcode == dmcm_pkg::OP_LOAD_A) && !full_a;
   assign wr_b = accept && (req_opcode == dmcm_pkg::OP_LOAD_B) && !full_b;

   dmcm_ram #(
      .WIDTH (dmcm_pkg::ENTRY_W),
      .DEPTH (MAX_PAIRS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (addr_a),
      .rd_data (ent_a)
   );

   dmcm_ram #(
      .WIDTH (dmcm_pkg::ENTRY_W),
      .DEPTH (MAX_PAIRS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (addr_b),
      .rd_data (ent_b)
   );

   // ------------------------------------------------------------------------
   // Shared cost unit, stage 1: two absolute differences
   // ------------------------------------------------------------------------
   logic [dmcm_pkg::VAL_W-1:0] op_x1, op_y1, op_x2, op_y2;
   logic signed [DW-1:0]       dxy1, dyx1, dxy2, dyx2;
   logic                       op_inf_a, op_inf_b;

   always_comb begin
      op_x1    = ent_a.birth;
      op_y1    = ent_b.birth;
      op_x2    = ent_a.death;
      op_y2    = ent_b.death;
      op_inf_a = ent_a.infinite;
      op_inf_b = ent_b.infinite;
      case (rd_op_ff)
         dmcm_pkg::UOP_DIAG_A: begin
            op_x1    = ent_a.death;
            op_y1    = ent_a.birth;
            op_inf_a = ent_a.infinite;
         end
         dmcm_pkg::UOP_DIAG_B: begin
            op_x1    = ent_b.death;
            op_y1    = ent_b.birth;
            op_inf_a = ent_b.infinite;
         end
         default: op_inf_a = ent_a.infinite;
      endcase
      dxy1 = DW'($signed(op_x1)) - DW'($signed(op_y1));
      dyx1 = DW'($signed(op_y1)) - DW'($signed(op_x1));
      dxy2 = DW'($signed(op_x2)) - DW'($signed(op_y2));
      dyx2 = DW'($signed(op_y2)) - DW'($signed(op_x2));
   end

   // Stage 2: combine into one cost and its finite flag.
   logic [DW-1:0]  s2_val_in;
   logic [DW:0]    half_sum;
   logic           s2_fin_in;

   always_comb begin
      half_sum  = (DW + 1)'(s1_d1_ff) + (DW + 1)'(1);
      s2_val_in = half_sum[DW:1];
      s2_fin_in = !s1_inf_a_ff;
      if (s1_op_ff == dmcm_pkg::UOP_PAIR) begin
         s2_fin_in = (s1_inf_a_ff == s1_inf_b_ff);
         if (s1_inf_a_ff || s1_d1_ff > s1_d2_ff) begin
            s2_val_in = s1_d1_ff;
         end else begin
            s2_val_in = s1_d2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= iss_vld;
         s1_vld_ff <= rd_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
      rd_op_ff    <= iss_op;
      s1_op_ff    <= rd_op_ff;
      s1_d1_ff    <= dxy1[DW-1] ? DW'(dyx1) : DW'(dxy1);
      s1_d2_ff    <= dxy2[DW-1] ? DW'(dyx2) : DW'(dxy2);
      s1_inf_a_ff <= op_inf_a;
      s1_inf_b_ff <= op_inf_b;
      s2_val_ff   <= s2_val_in;
      s2_fin_ff   <= s2_fin_in;
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmcm_pkg::S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ready_ff     <= 1'b0;
         max_ff       <= dmcm_pkg::ONE_FIX;
         penalty_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= resp.fire;
         if (accept) begin
            unique case (req_opcode)
               dmcm_pkg::OP_CLEAR: begin
                  count_a_ff <= '0;
                  count_b_ff <= '0;
                  max_ff     <= dmcm_pkg::ONE_FIX;
                  penalty_ff <= '0;
                  ready_ff   <= 1'b0;
               end
               dmcm_pkg::OP_LOAD_A: begin
                  if (!full_a) begin
                     count_a_ff <= count_a_ff + CNT_W'(1);
                     ready_ff   <= 1'b0;
                  end
               end
               dmcm_pkg::OP_LOAD_B: begin
                  if (!full_b) begin
                     count_b_ff <= count_b_ff + CNT_W'(1);
                     ready_ff   <= 1'b0;
                  end
               end
               dmcm_pkg::OP_FINISH: begin
                  max_ff <= dmcm_pkg::ONE_FIX;
                  i_ff   <= '0;
                  j_ff   <= '0;
               end
               default: ;
            endcase
         end
         case (state_ff)
            dmcm_pkg::S_FIN_PAIR: begin
               if (pair_last) begin
                  i_ff <= '0;
                  j_ff <= '0;
               end else if (b_last) begin
                  i_ff <= i_ff + CNT_W'(1);
                  j_ff <= '0;
               end else begin
                  j_ff <= j_ff + CNT_W'(1);
               end
            end
            dmcm_pkg::S_FIN_DIAG_A: i_ff <= i_ff + CNT_W'(1);
            dmcm_pkg::S_FIN_DIAG_B: j_ff <= j_ff + CNT_W'(1);
            dmcm_pkg::S_FIN_SUM: begin
               penalty_ff <= pen_sat;
               ready_ff   <= 1'b1;
            end
            default: ;
         endcase
         // The running maximum takes finite costs during the finish walk and its drain.
         if (s2_vld_ff && s2_fin_ff && s2_val_ff > max_ff &&
             (state_ff == dmcm_pkg::S_FIN_PAIR || state_ff == dmcm_pkg::S_FIN_DIAG_A ||
              state_ff == dmcm_pkg::S_FIN_DIAG_B || state_ff == dmcm_pkg::S_FIN_DRAIN)) begin
            max_ff <= s2_val_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(max_ff) * PROD_W'(n_cur + XW'(1));
      if (accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (resp.fire) begin
         rsp_cost_ff   <= resp.cost;
         rsp_status_ff <= resp.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cost   = rsp_cost_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_size   = n_cur[dmcm_pkg::SIZE_W-1:0];

endmodule

### sim/diagram_matching_cost_matrix_test.sv
// ----------------------------------------------------------------------------
// diagram_matching_cost_matrix_test
// Self-checking bench for the persistence diagram cost matrix block. A queue
// of command items (clear, loads, finish, reads and unused opcodes) feeds a
// clocked driver. A clocked monitor predicts every accepted item with its own
// model of the stores, counts and penalty, and compares each result strobe
// field by field with the oldest prediction. Directed corner cases come first,
// then randomized diagram sessions under three sender idle rates, closing with
// one session that fills store A to capacity.
// ----------------------------------------------------------------------------
module diagram_matching_cost_matrix_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAIRS = 256;
   localparam logic [dmcm_pkg::OPC_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [dmcm_pkg::OPC_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [dmcm_pkg::OPC_W-1:0] OP_UNUSED_HI  = 3'd7;
   localparam longint unsigned COST_MAX = (64'd1 << dmcm_pkg::COST_W) - 64'd1;

   typedef struct {
      logic [dmcm_pkg::OPC_W-1:0]        opcode;
      logic signed [dmcm_pkg::VAL_W-1:0] birth;
      logic signed [dmcm_pkg::VAL_W-1:0] death;
      logic                              infinite;
      logic [dmcm_pkg::IDX_W-1:0]        row;
      logic [dmcm_pkg::IDX_W-1:0]        col;
   } matrix_cmd_type;

   typedef struct {
      logic [dmcm_pkg::COST_W-1:0]   cost;
      logic [dmcm_pkg::STATUS_W-1:0] status;
      logic [dmcm_pkg::SIZE_W-1:0]   size;
   } matrix_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [dmcm_pkg::OPC_W-1:0]        req_opcode = '0;
   logic signed [dmcm_pkg::VAL_W-1:0] req_birth = '0;
   logic signed [dmcm_pkg::VAL_W-1:0] req_death = '0;
   logic                              req_infinite = 1'b0;
   logic [dmcm_pkg::IDX_W-1:0]        req_row = '0;
   logic [dmcm_pkg::IDX_W-1:0]        req_col = '0;
   logic                              rsp_valid;
   logic [dmcm_pkg::COST_W-1:0]       rsp_cost;
   logic [dmcm_pkg::STATUS_W-1:0]     rsp_status;
   logic [dmcm_pkg::SIZE_W-1:0]       rsp_size;

   diagram_matching_cost_matrix #(.MAX_PAIRS(PAIRS)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_birth    (req_birth),
      .req_death    (req_death),
      .req_infinite (req_infinite),
      .req_row      (req_row),
      .req_col      (req_col),
      .rsp_valid    (rsp_valid),
      .rsp_cost     (rsp_cost),
      .rsp_status   (rsp_status),
      .rsp_size     (rsp_size)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted contents of the block.
   logic signed [dmcm_pkg::VAL_W-1:0] a_birth [PAIRS];
   logic signed [dmcm_pkg::VAL_W-1:0] a_death [PAIRS];
   logic                              a_inf   [PAIRS];
   logic signed [dmcm_pkg::VAL_W-1:0] b_birth [PAIRS];
   logic signed [dmcm_pkg::VAL_W-1:0] b_death [PAIRS];
   logic                              b_inf   [PAIRS];
   int                                cnt_a = 0;
   int                                cnt_b = 0;
   logic [dmcm_pkg::DIFF_W-1:0]       largest = dmcm_pkg::ONE_FIX;
   logic [dmcm_pkg::COST_W-1:0]       penalty = '0;
   bit                                ready = 1'b0;

   matrix_cmd_type    pending_cmds [$];
   matrix_answer_type due_answers [$];
   int           sender_idle_pct = 32;
   bit           taken = 1'b0;
   int           mismatches = 0;
   int           queued = 0;
   int           n_accepted = 0;
   int           n_finish = 0;
   int           n_reads = 0;
   int           widest = 0;
   int           stim_na = 0;
   int           stim_nb = 0;

   function automatic logic [dmcm_pkg::DIFF_W-1:0] abs_gap(
         logic signed [dmcm_pkg::VAL_W-1:0] x, logic signed [dmcm_pkg::VAL_W-1:0] y);
      longint d;
      d = longint'(x) - longint'(y);
      return (d < 0) ? dmcm_pkg::DIFF_W'(-d) : dmcm_pkg::DIFF_W'(d);
   endfunction

   function automatic logic [dmcm_pkg::DIFF_W-1:0] pair_gap(int i, int j, output bit fin);
      logic [dmcm_pkg::DIFF_W-1:0] gb, gd;
      fin = 1'b1;
      if (a_inf[i] && b_inf[j]) return abs_gap(a_birth[i], b_birth[j]);
      if (a_inf[i] != b_inf[j]) begin
         fin = 1'b0;
         return '0;
      end
      gb = abs_gap(a_birth[i], b_birth[j]);
      gd = abs_gap(a_death[i], b_death[j]);
      return (gb > gd) ? gb : gd;
   endfunction

   // Half lifetime, rounded to nearest with ties upward.
   function automatic logic [dmcm_pkg::DIFF_W-1:0] diag_gap(
         logic signed [dmcm_pkg::VAL_W-1:0] b, logic signed [dmcm_pkg::VAL_W-1:0] d,
         logic inf, output bit fin);
      logic [dmcm_pkg::DIFF_W:0] g;
      fin = !inf;
      if (inf) return '0;
      g = {1'b0, abs_gap(d, b)} + (dmcm_pkg::DIFF_W + 1)'(1);
      return g[dmcm_pkg::DIFF_W:1];
   endfunction

   function automatic matrix_answer_type compute_answer(matrix_cmd_type c);
      matrix_answer_type ans;
      logic [dmcm_pkg::DIFF_W-1:0] v;
      longint unsigned p;
      bit fin;
      int n, r, k;
      ans.cost = '0;
      ans.status = dmcm_pkg::STAT_OK;
      r = int'(c.row);
      k = int'(c.col);
      case (c.opcode)
         dmcm_pkg::OP_CLEAR: begin
            cnt_a = 0;
            cnt_b = 0;
            largest = dmcm_pkg::ONE_FIX;
            penalty = '0;
            ready = 1'b0;
         end
         dmcm_pkg::OP_LOAD_A: begin
            if (cnt_a >= PAIRS) ans.status = dmcm_pkg::STAT_FULL;
            else begin
               a_birth[cnt_a] = c.birth;
               a_death[cnt_a] = c.death;
               a_inf[cnt_a] = c.infinite;
               cnt_a++;
               ready = 1'b0;
            end
         end
         dmcm_pkg::OP_LOAD_B: begin
            if (cnt_b >= PAIRS) ans.status = dmcm_pkg::STAT_FULL;
            else begin
               b_birth[cnt_b] = c.birth;
               b_death[cnt_b] = c.death;
               b_inf[cnt_b] = c.infinite;
               cnt_b++;
               ready = 1'b0;
            end
         end
         dmcm_pkg::OP_FINISH: begin
            largest = dmcm_pkg::ONE_FIX;
            for (int i = 0; i < cnt_a; i++)
               for (int j = 0; j < cnt_b; j++) begin
                  v = pair_gap(i, j, fin);
                  if (fin && v > largest) largest = v;
               end
            for (int i = 0; i < cnt_a; i++) begin
               v = diag_gap(a_birth[i], a_death[i], a_inf[i], fin);
               if (fin && v > largest) largest = v;
            end
            for (int j = 0; j < cnt_b; j++) begin
               v = diag_gap(b_birth[j], b_death[j], b_inf[j], fin);
               if (fin && v > largest) largest = v;
            end
            p = longint'(largest) * longint'(cnt_a + cnt_b + 1) +
                longint'(dmcm_pkg::ONE_FIX);
            penalty = (p > COST_MAX) ? dmcm_pkg::COST_W'(COST_MAX) : dmcm_pkg::COST_W'(p);
            ready = 1'b1;
            ans.cost = penalty;
         end
         dmcm_pkg::OP_READ: begin
            n = cnt_a + cnt_b;
            if (!ready) ans.status = dmcm_pkg::STAT_NOT_READY;
            else if (r >= n || k >= n) ans.status = dmcm_pkg::STAT_RANGE;
            else begin
               fin = 1'b1;
               v = '0;
               if (r < cnt_a && k < cnt_b) v = pair_gap(r, k, fin);
               else if (r < cnt_a) begin
                  if (k - cnt_b == r) v = diag_gap(a_birth[r], a_death[r], a_inf[r], fin);
                  else fin = 1'b0;
               end else if (k < cnt_b) begin
                  if (r - cnt_a == k) v = diag_gap(b_birth[k], b_death[k], b_inf[k], fin);
                  else fin = 1'b0;
               end
               // The auxiliary block keeps fin set and v at zero.
               ans.cost = fin ? dmcm_pkg::COST_W'(v) : penalty;
            end
         end
         default: ;
      endcase
      ans.size = dmcm_pkg::SIZE_W'(cnt_a + cnt_b);
      return ans;
   endfunction

   // Driver: a held item stays on the ports until the block takes it.
   always @(negedge clock) begin
      matrix_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            c = pending_cmds.pop_front();
            start <= 1'b1;
            req_opcode <= c.opcode;
            req_birth <= c.birth;
            req_death <= c.death;
            req_infinite <= c.infinite;
            req_row <= c.row;
            req_col <= c.col;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks result strobes and predicts each accepted item.
   always @(posedge clock) begin
      matrix_cmd_type c;
      matrix_answer_type want;
      if (!reset && rsp_valid) begin
         if (due_answers.size() == 0) begin
            $error("result with no item outstanding: cost %0h status %0d size %0d",
                   rsp_cost, rsp_status, rsp_size);
            mismatches++;
         end else begin
            want = due_answers.pop_front();
            if (rsp_cost !== want.cost) begin
               $error("cost: expected %0h, actual %0h", want.cost, rsp_cost);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_size !== want.size) begin
               $error("size: expected %0d, actual %0d", want.size, rsp_size);
               mismatches++;
            end
         end
      end
      if (!reset && start && busy == 1'b0) begin
         c.opcode = req_opcode;
         c.birth = req_birth;
         c.death = req_death;
         c.infinite = req_infinite;
         c.row = req_row;
         c.col = req_col;
         want = compute_answer(c);
         due_answers.push_back(want);
         n_accepted++;
         if (c.opcode == dmcm_pkg::OP_FINISH) n_finish++;
         if (c.opcode == dmcm_pkg::OP_READ && want.status == dmcm_pkg::STAT_OK) n_reads++;
         if (int'(want.size) > widest) widest = int'(want.size);
         taken <= 1'b1;
      end else begin
         taken <= 1'b0;
      end
   end

   function automatic logic signed [dmcm_pkg::VAL_W-1:0] rand_val();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   task automatic send(logic [dmcm_pkg::OPC_W-1:0] op, logic signed [dmcm_pkg::VAL_W-1:0] b,
                       logic signed [dmcm_pkg::VAL_W-1:0] d, logic inf, int r, int c);
      matrix_cmd_type m;
      m.opcode = op;
      m.birth = b;
      m.death = d;
      m.infinite = inf;
      m.row = dmcm_pkg::IDX_W'(r);
      m.col = dmcm_pkg::IDX_W'(c);
      pending_cmds.push_back(m);
      queued++;
      case (op)
         dmcm_pkg::OP_CLEAR: begin
            stim_na = 0;
            stim_nb = 0;
         end
         dmcm_pkg::OP_LOAD_A: if (stim_na < PAIRS) stim_na++;
         dmcm_pkg::OP_LOAD_B: if (stim_nb < PAIRS) stim_nb++;
         default: ;
      endcase
   endtask

   // Fields the opcode ignores carry random bits.
   task automatic send_bare(logic [dmcm_pkg::OPC_W-1:0] op);
      send(op, $urandom, $urandom, 1'($urandom_range(1)), $urandom_range(511),
           $urandom_range(511));
   endtask

   task automatic send_read(int r, int c);
      send(dmcm_pkg::OP_READ, $urandom, $urandom, 1'($urandom_range(1)), r, c);
   endtask

   task automatic send_load(logic [dmcm_pkg::OPC_W-1:0] op);
      logic signed [dmcm_pkg::VAL_W-1:0] b, d;
      b = rand_val();
      if ($urandom_range(1)) d = b + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
      else d = rand_val();
      send(op, b, d, $urandom_range(4) == 0, $urandom_range(511), $urandom_range(511));
   endtask

   // One diagram session: loads, finish, then reads, with some noise mixed in.
   task automatic random_session();
      int na, nb, la, lb, nr, n, i;
      if ($urandom_range(9) != 0 || stim_na > 200 || stim_nb > 200)
         send_bare(dmcm_pkg::OP_CLEAR);
      na = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      nb = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      la = 0;
      lb = 0;
      while (la < na || lb < nb) begin
         if (lb >= nb || (la < na && $urandom_range(1))) begin
            send_load(dmcm_pkg::OP_LOAD_A);
            la++;
         end else begin
            send_load(dmcm_pkg::OP_LOAD_B);
            lb++;
         end
         if ($urandom_range(19) == 0) send_read($urandom_range(7), $urandom_range(7));
      end
      send_bare(dmcm_pkg::OP_FINISH);
      n = stim_na + stim_nb;
      nr = $urandom_range(1, 8);
      for (int k = 0; k < nr; k++) begin
         case ($urandom_range(9))
            0: send_read($urandom_range(511), $urandom_range(511));
            1, 2: begin
               if (stim_na > 0) begin
                  i = $urandom_range(stim_na - 1);
                  send_read(i, stim_nb + i);
               end else if (stim_nb > 0) begin
                  i = $urandom_range(stim_nb - 1);
                  send_read(stim_na + i, i);
               end else begin
                  send_read(0, 0);
               end
            end
            3: begin
               if (stim_nb > 0) begin
                  i = $urandom_range(stim_nb - 1);
                  send_read(stim_na + i, i);
               end else begin
                  send_read(n, $urandom_range(511));
               end
            end
            default: begin
               if (n > 0) send_read($urandom_range(n - 1), $urandom_range(n - 1));
               else send_read($urandom_range(3), $urandom_range(3));
            end
         endcase
      end
      case ($urandom_range(9))
         0: send_bare(dmcm_pkg::OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
         1: begin
            // A late load drops the ready flag until the next finish.
            send_load($urandom_range(1) ? dmcm_pkg::OP_LOAD_A : dmcm_pkg::OP_LOAD_B);
            send_read(0, 0);
            if ($urandom_range(1)) begin
               send_bare(dmcm_pkg::OP_FINISH);
               n = stim_na + stim_nb;
               send_read($urandom_range(n - 1), $urandom_range(n - 1));
            end
         end
         2: begin
            send_bare(dmcm_pkg::OP_CLEAR);
            send_read($urandom_range(511), $urandom_range(511));
         end
         default: ;
      endcase
   endtask

   initial begin
      int goal;
      // Directed corner cases.
      send_read(0, 0);
      send_bare(dmcm_pkg::OP_FINISH);
      send_read(0, 0);
      send_bare(OP_UNUSED_LO);
      send_bare(OP_UNUSED_MID);
      send_bare(OP_UNUSED_HI);
      send(dmcm_pkg::OP_LOAD_A, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 511, 0);
      send(dmcm_pkg::OP_LOAD_A, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 0, 511);
      send(dmcm_pkg::OP_LOAD_B, 32'sh8000_0000, 32'sh0000_0000, 1'b1, 511, 511);
      send(dmcm_pkg::OP_LOAD_B, 32'sh0000_0000, 32'sh0000_0001, 1'b0, 0, 0);
      send_read(0, 0);
      send_bare(dmcm_pkg::OP_FINISH);
      send_read(0, 0);
      send_read(1, 0);
      send_read(0, 1);
      send_read(1, 1);
      send_read(0, 2);
      send_read(1, 3);
      send_read(0, 3);
      send_read(2, 0);
      send_read(3, 1);
      send_read(2, 2);
      send_read(3, 3);
      send_read(4, 0);
      send_read(511, 511);
      send_load(dmcm_pkg::OP_LOAD_A);
      send_read(0, 0);
      send_bare(dmcm_pkg::OP_CLEAR);
      send_read(0, 0);

      goal = 100;
      while (queued < goal) random_session();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0) @(posedge clock);
      sender_idle_pct = 78;
      goal += 85;
      while (queued < goal) random_session();

      while (pending_cmds.size() != 0) @(posedge clock);
      sender_idle_pct = 0;
      goal += 85;
      while (queued < goal) random_session();

      // Store A filled to capacity, one more load reports full.
      send_bare(dmcm_pkg::OP_CLEAR);
      for (int k = 0; k <= PAIRS; k++) send_load(dmcm_pkg::OP_LOAD_A);
      for (int k = 0; k < 3; k++) send_load(dmcm_pkg::OP_LOAD_B);
      send_bare(dmcm_pkg::OP_FINISH);
      send_read(511, 511);
      send_read(0, 0);
      send_read(255, 2);
      send_read(255, 258);
      send_read(256, 0);
      send_read(258, 2);
      send_read(257, 5);
      send_read(300, 10);
      send_read(10, 300);
      for (int k = 0; k < 10; k++) send_read($urandom_range(511), $urandom_range(511));
      send_load(dmcm_pkg::OP_LOAD_A);
      send_read(0, 0);

      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (due_answers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Run covered %0d items: %0d finish passes and %0d matrix entry reads.",
               n_accepted, n_finish, n_reads);
      $display("Largest matrix dimension reached: %0d.", widest);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out waiting for results.");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hdl/dmcm_pkg.sv
hdl/dmcm_ram.sv
hdl/diagram_matching_cost_matrix.sv
sim/diagram_matching_cost_matrix_test.sv
